// ----- rtl/core/fte_pkg.sv -----
// Shared widths, types and helpers of the toroidal field evaluator.
package fte_pkg;

	// Coordinate and field widths.
	localparam int CW = 32;
	localparam int FW = 18;
	// Unsigned length registers drop the sign bit.
	localparam int LW = CW - 1;
	// Sum of two squared lengths.
	localparam int SW = 2 * LW + 1;
	// Square root of that sum, with room for the rounding step.
	localparam int RW = (SW + 1) / 2;
	// Trial value of one square-root step.
	localparam int TW = 2 * RW + 1;
	// Quotient bits of a field component, one above the field magnitude.
	localparam int QW = FW + 1;
	// Dividend: field magnitude times a length plus half the radius.
	localparam int NW = FW + LW;
	// Signed width used before saturation.
	localparam int EW = QW + 2;
	// Register index width.
	localparam int IW = 3;

	localparam logic signed [EW-1:0] FMAX = EW'((64'sd1 <<< (FW - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] FMIN = -FMAX - EW'(1);

	typedef enum logic [IW-1:0] {
		REG_Y_OFFSET,
		REG_Z_OFFSET,
		REG_Z_LENGTH,
		REG_AP_HALF_W,
		REG_AP_HALF_H,
		REG_OUT_HALF_H,
		REG_FIELD
	} reg_idx_t;

	typedef struct packed {
		logic signed [CW-1:0] y_off;
		logic signed [CW-1:0] z_off;
		logic [LW-1:0]        z_len;
		logic [LW-1:0]        ap_hw;
		logic [LW-1:0]        ap_hh;
		logic [LW-1:0]        out_hh;
		logic signed [FW-1:0] field;
	} cfg_t;

	// Region and sign flags of one word.
	typedef struct packed {
		logic ap_hit;
		logic rg_hit;
		logic x_neg;
		logic y_neg;
	} meta_t;

	// What rides along the square-root pipeline.
	typedef struct packed {
		meta_t         meta;
		logic [NW-1:0] px;
		logic [NW-1:0] py;
	} sq_side_t;

	// Clamp to the signed field range.
	function automatic logic signed [FW-1:0] sat_field(input logic signed [EW-1:0] v);
		logic signed [EW-1:0] c;
		c = v;
		if (v > FMAX) c = FMAX;
		if (v < FMIN) c = FMIN;
		return $signed(c[FW-1:0]);
	endfunction

endpackage

// ----- rtl/core/fte_ifs.sv -----
// Valid/ready channels carrying a point word and a field word.
interface fte_in_if;
	import fte_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] x_pos;
	logic signed [CW-1:0] y_pos;
	logic signed [CW-1:0] z_pos;
	modport source (output valid, x_pos, y_pos, z_pos, input ready);
	modport sink (input valid, x_pos, y_pos, z_pos, output ready);
endinterface

interface fte_out_if;
	import fte_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [FW-1:0] field_x;
	logic signed [FW-1:0] field_y;
	modport source (output valid, field_x, field_y, input ready);
	modport sink (input valid, field_x, field_y, output ready);
endinterface

// ----- rtl/core/fte_front.sv -----
// Geometry front end: offsets, region tests, squares and the radius sum.
module fte_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  fte_pkg::cfg_t                cfg,
	input  logic                         in_vld,
	input  logic signed [fte_pkg::CW-1:0] x_pos,
	input  logic signed [fte_pkg::CW-1:0] y_pos,
	input  logic signed [fte_pkg::CW-1:0] z_pos,
	output logic                         out_vld,
	output logic [fte_pkg::SW-1:0]       s_out,
	output fte_pkg::sq_side_t            side_out
);
	import fte_pkg::*;

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                xneg_s1, xneg_s2, xneg_s3, xneg_s4;
	logic [CW-1:0]       ax_s1;
	logic signed [CW:0]  y_s1, z_s1;
	logic                yneg_s2, yneg_s3, yneg_s4;
	logic [CW:0]         ay_s2;
	logic                zok_s2, inap_s2;
	logic [CW-1:0]       dx_s2;
	logic                ap_s3, ap_s4, rgc_s3, rgc_s4;
	logic [2*LW-1:0]     dx2_s3, ay2_s3, hh2_s3, hh2_s4, oh2_s3, oh2_s4;
	logic [NW-1:0]       px_s3, py_s3, px_s4, py_s4;
	logic [SW-1:0]       s_s4, s_s5;
	sq_side_t            side_s5;

	logic [CW:0]         ay, az;
	logic [LW-1:0]       dx_l, ay_l;
	logic [FW-1:0]       fmag;
	logic [2*LW-1:0]     dx2, ay2, hh2, oh2;
	logic [NW-1:0]       px, py;
	logic                ap_hit, rg_cand, rg_hit;

	// Valid bits follow the words through the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage 1: magnet frame and |x|.
	always_ff @(posedge clk) begin
		if (adv) begin
			xneg_s1 <= x_pos[CW-1];
			ax_s1   <= x_pos[CW-1] ? unsigned'(-x_pos) : unsigned'(x_pos);
			y_s1    <= (CW+1)'(y_pos) - (CW+1)'(cfg.y_off);
			z_s1    <= (CW+1)'(z_pos) - (CW+1)'(cfg.z_off);
		end
	end

	// Stage 2: magnitudes, length test and distance from the aperture edge.
	assign ay = y_s1[CW] ? unsigned'(-y_s1) : unsigned'(y_s1);
	assign az = z_s1[CW] ? unsigned'(-z_s1) : unsigned'(z_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			xneg_s2 <= xneg_s1;
			yneg_s2 <= y_s1[CW];
			ay_s2   <= ay;
			zok_s2  <= {az, 1'b0} <= (CW+2)'(cfg.z_len);
			inap_s2 <= ax_s1 < CW'(cfg.ap_hw);
			dx_s2   <= ax_s1 - CW'(cfg.ap_hw);
		end
	end

	// Stage 3: region pretests and the squares and products.
	assign dx_l    = dx_s2[LW-1:0];
	assign ay_l    = ay_s2[LW-1:0];
	assign fmag    = cfg.field[FW-1] ? unsigned'(-cfg.field) : unsigned'(cfg.field);
	assign dx2     = dx_l * dx_l;
	assign ay2     = ay_l * ay_l;
	assign hh2     = cfg.ap_hh * cfg.ap_hh;
	assign oh2     = cfg.out_hh * cfg.out_hh;
	assign px      = fmag * ay_l;
	assign py      = fmag * dx_l;
	assign ap_hit  = zok_s2 && inap_s2 && (ay_s2 > (CW+1)'(cfg.ap_hh))
		&& (ay_s2 < (CW+1)'(cfg.out_hh));
	assign rg_cand = zok_s2 && !inap_s2 && (dx_s2 < CW'(cfg.out_hh))
		&& (ay_s2 < (CW+1)'(cfg.out_hh));

	always_ff @(posedge clk) begin
		if (adv) begin
			xneg_s3 <= xneg_s2;
			yneg_s3 <= yneg_s2;
			ap_s3   <= ap_hit;
			rgc_s3  <= rg_cand;
			dx2_s3  <= dx2;
			ay2_s3  <= ay2;
			hh2_s3  <= hh2;
			oh2_s3  <= oh2;
			px_s3   <= px;
			py_s3   <= py;
		end
	end

	// Stage 4: squared radius.
	always_ff @(posedge clk) begin
		if (adv) begin
			xneg_s4 <= xneg_s3;
			yneg_s4 <= yneg_s3;
			ap_s4   <= ap_s3;
			rgc_s4  <= rgc_s3;
			s_s4    <= SW'(dx2_s3) + SW'(ay2_s3);
			hh2_s4  <= hh2_s3;
			oh2_s4  <= oh2_s3;
			px_s4   <= px_s3;
			py_s4   <= py_s3;
		end
	end

	// Stage 5: the radius must lie strictly between the half heights.
	assign rg_hit = rgc_s4 && (s_s4 > SW'(hh2_s4)) && (s_s4 < SW'(oh2_s4));

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s5                <= s_s4;
			side_s5.meta.ap_hit <= ap_s4;
			side_s5.meta.rg_hit <= rg_hit;
			side_s5.meta.x_neg  <= xneg_s4;
			side_s5.meta.y_neg  <= yneg_s4;
			side_s5.px          <= px_s4;
			side_s5.py          <= py_s4;
		end
	end

	assign out_vld  = vld_s5;
	assign s_out    = s_s5;
	assign side_out = side_s5;

endmodule

// ----- rtl/core/fte_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, rounded to nearest.
module fte_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_vld,
	input  logic [fte_pkg::SW-1:0] s_in,
	input  fte_pkg::sq_side_t      side_in,
	output logic                   out_vld,
	output logic [fte_pkg::RW-1:0] root_out,
	output fte_pkg::sq_side_t      side_out
);
	import fte_pkg::*;

	logic          vld_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [SW-1:0] rem_s  [RW];
	sq_side_t      side_s [RW];

	logic [RW-1:0] root_in [RW];
	logic [SW-1:0] rem_in  [RW];
	logic [TW-1:0] trial   [RW];
	logic          take    [RW];

	logic          vld_rnd_s;
	logic [RW-1:0] root_rnd_s;
	sq_side_t      side_rnd_s;

	// Each stage sees the previous stage, the first one sees the input.
	always_comb begin
		root_in[0] = '0;
		rem_in[0]  = s_in;
		for (int k = 1; k < RW; k++) begin
			root_in[k] = root_s[k-1];
			rem_in[k]  = rem_s[k-1];
		end
	end

	// Try the next root bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 4^b.
	always_comb begin
		for (int k = 0; k < RW; k++) begin
			trial[k] = (TW'(root_in[k]) << (RW - k)) + (TW'(1) << (2 * (RW - 1 - k)));
			take[k]  = TW'(rem_in[k]) >= trial[k];
		end
	end

	// Valid bits, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RW; k++) vld_s[k] <= 1'b0;
			vld_rnd_s <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k < RW; k++) vld_s[k] <= vld_s[k-1];
			vld_rnd_s <= vld_s[RW-1];
		end
	end

	// Root and remainder stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_in;
			for (int k = 1; k < RW; k++) side_s[k] <= side_s[k-1];
			for (int k = 0; k < RW; k++) begin
				root_s[k] <= take[k] ? (root_in[k] | (RW'(1) << (RW - 1 - k))) : root_in[k];
				rem_s[k]  <= take[k] ? SW'(TW'(rem_in[k]) - trial[k]) : rem_in[k];
			end
		end
	end

	// Round up when s exceeds r^2 + r.
	always_ff @(posedge clk) begin
		if (adv) begin
			root_rnd_s <= root_s[RW-1] + RW'(rem_s[RW-1] > SW'(root_s[RW-1]));
			side_rnd_s <= side_s[RW-1];
		end
	end

	assign out_vld  = vld_rnd_s;
	assign root_out = root_rnd_s;
	assign side_out = side_rnd_s;

endmodule

// ----- rtl/core/fte_div.sv -----
// Pipelined restoring divider for both field components over one radius.
module fte_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_vld,
	input  fte_pkg::meta_t         meta_in,
	input  logic [fte_pkg::NW-1:0] px,
	input  logic [fte_pkg::NW-1:0] py,
	input  logic [fte_pkg::RW-1:0] den,
	output logic                   out_vld,
	output fte_pkg::meta_t         meta_out,
	output logic [fte_pkg::QW-1:0] qx,
	output logic [fte_pkg::QW-1:0] qy
);
	import fte_pkg::*;

	// Stage 0 forms the rounded dividends, stages 1..QW each yield a bit.
	logic          vld_s  [QW+1];
	meta_t         meta_s [QW+1];
	logic [NW-1:0] nx_s   [QW+1];
	logic [NW-1:0] ny_s   [QW+1];
	logic [RW-1:0] den_s  [QW+1];
	logic [RW-1:0] rx_s   [QW+1];
	logic [RW-1:0] ry_s   [QW+1];
	logic [QW-1:0] qx_s   [QW+1];
	logic [QW-1:0] qy_s   [QW+1];

	logic [NW-1:0] nx, ny;
	logic [RW:0]   rx2 [QW+1];
	logic [RW:0]   ry2 [QW+1];
	logic          tx  [QW+1];
	logic          ty  [QW+1];

	assign nx = px + NW'(den >> 1);
	assign ny = py + NW'(den >> 1);

	// Shift in the next dividend bit and compare with the divisor.
	always_comb begin
		rx2[0] = '0;
		ry2[0] = '0;
		tx[0]  = 1'b0;
		ty[0]  = 1'b0;
		for (int j = 1; j <= QW; j++) begin
			rx2[j] = {rx_s[j-1], nx_s[j-1][QW-j]};
			ry2[j] = {ry_s[j-1], ny_s[j-1][QW-j]};
			tx[j]  = rx2[j] >= {1'b0, den_s[j-1]};
			ty[j]  = ry2[j] >= {1'b0, den_s[j-1]};
		end
	end

	// Valid bits, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QW; j++) vld_s[j] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
			for (int j = 1; j <= QW; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	// Dividend setup and quotient stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s[0] <= meta_in;
			nx_s[0]   <= nx;
			ny_s[0]   <= ny;
			den_s[0]  <= den;
			rx_s[0]   <= RW'(nx >> QW);
			ry_s[0]   <= RW'(ny >> QW);
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			for (int j = 1; j <= QW; j++) begin
				meta_s[j] <= meta_s[j-1];
				nx_s[j]   <= nx_s[j-1];
				ny_s[j]   <= ny_s[j-1];
				den_s[j]  <= den_s[j-1];
				rx_s[j]   <= tx[j] ? RW'(rx2[j] - {1'b0, den_s[j-1]}) : RW'(rx2[j]);
				ry_s[j]   <= ty[j] ? RW'(ry2[j] - {1'b0, den_s[j-1]}) : RW'(ry2[j]);
				qx_s[j]   <= qx_s[j-1] | (QW'(tx[j]) << (QW - j));
				qy_s[j]   <= qy_s[j-1] | (QW'(ty[j]) << (QW - j));
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign meta_out = meta_s[QW];
	assign qx       = qx_s[QW];
	assign qy       = qy_s[QW];

endmodule

// ----- rtl/core/toroidal_field_evaluator.sv -----
// Top level of the toroidal field evaluator.
//
// Usage: one point word (x_pos, y_pos, z_pos) enters on pt_in and one field
// word (field_x, field_y) leaves on fld_out, both valid/ready channels; a
// word moves at a clock edge where valid and ready are both high.
// Magnet geometry and field strength are written through wr_en, wr_index and
// wr_data while no word is in flight; unknown indexes are ignored.
// From acceptance to the field word showing on fld_out, a word passes through
// five geometry stages, 32 square-root stages plus rounding, a dividend stage,
// 19 quotient stages and the output register.
// Throughput is one word per cycle while the receiver takes words.
// Reset clears the configuration registers to zero and empties the pipeline,
// so no field word is shown until a point word has gone through.
// When the receiver stalls a shown field word, the whole pipeline holds and
// pt_in.ready drops; no word is lost or repeated.
module toroidal_field_evaluator (
	input  logic                   clk,
	input  logic                   arst_n,
	fte_in_if.sink                 pt_in,
	fte_out_if.source              fld_out,
	input  logic                   wr_en,
	input  logic [fte_pkg::IW-1:0] wr_index,
	input  logic [fte_pkg::CW-1:0] wr_data
);
	import fte_pkg::*;

	cfg_t                 cfg_q;
	logic                 adv;
	logic                 out_vld_q;
	logic signed [FW-1:0] field_x_q, field_y_q;

	logic                 fr_vld, sq_vld, dv_vld;
	logic [SW-1:0]        fr_s;
	sq_side_t             fr_side, sq_side;
	logic [RW-1:0]        sq_root;
	meta_t                dv_meta;
	logic [QW-1:0]        dv_qx, dv_qy;

	logic                 fneg;
	logic signed [EW-1:0] fe, qxe, qye, bx, by;

	// The pipeline moves whenever the output register is free or being taken.
	assign adv         = !out_vld_q || fld_out.ready;
	assign pt_in.ready = adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_Y_OFFSET:   cfg_q.y_off  <= signed'(wr_data);
				REG_Z_OFFSET:   cfg_q.z_off  <= signed'(wr_data);
				REG_Z_LENGTH:   cfg_q.z_len  <= wr_data[LW-1:0];
				REG_AP_HALF_W:  cfg_q.ap_hw  <= wr_data[LW-1:0];
				REG_AP_HALF_H:  cfg_q.ap_hh  <= wr_data[LW-1:0];
				REG_OUT_HALF_H: cfg_q.out_hh <= wr_data[LW-1:0];
				REG_FIELD:      cfg_q.field  <= signed'(wr_data[FW-1:0]);
				default: ;
			endcase
		end
	end

	fte_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cfg      (cfg_q),
		.in_vld   (pt_in.valid),
		.x_pos    (pt_in.x_pos),
		.y_pos    (pt_in.y_pos),
		.z_pos    (pt_in.z_pos),
		.out_vld  (fr_vld),
		.s_out    (fr_s),
		.side_out (fr_side)
	);

	fte_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (fr_vld),
		.s_in     (fr_s),
		.side_in  (fr_side),
		.out_vld  (sq_vld),
		.root_out (sq_root),
		.side_out (sq_side)
	);

	fte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (sq_vld),
		.meta_in  (sq_side.meta),
		.px       (sq_side.px),
		.py       (sq_side.py),
		.den      (sq_root),
		.out_vld  (dv_vld),
		.meta_out (dv_meta),
		.qx       (dv_qx),
		.qy       (dv_qy)
	);

	// Signs: field direction, then the quadrant flips.
	assign fneg = cfg_q.field[FW-1];
	assign fe   = EW'(cfg_q.field);
	assign qxe  = signed'(EW'(dv_qx));
	assign qye  = signed'(EW'(dv_qy));

	always_comb begin
		bx = '0;
		by = '0;
		if (dv_meta.ap_hit) begin
			bx = fe;
		end else if (dv_meta.rg_hit) begin
			bx = fneg ? -qxe : qxe;
			by = fneg ? qye : -qye;
		end
		if (dv_meta.x_neg) by = -by;
		if (dv_meta.y_neg) bx = -bx;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			field_x_q <= sat_field(bx);
			field_y_q <= sat_field(by);
		end
	end

	assign fld_out.valid   = out_vld_q;
	assign fld_out.field_x = field_x_q;
	assign fld_out.field_y = field_y_q;

endmodule

// ----- rtl/core/fte_checker.sv -----
// Port-level checks of the toroidal field evaluator and their binding.
module fte_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [fte_pkg::FW-1:0] field_x,
	input logic signed [fte_pkg::FW-1:0] field_y
);
	import fte_pkg::*;

	// An empty output register never blocks the input side.
	a_ready_when_empty: assert property (@(posedge clk) !out_valid |-> in_ready)
		else $error("input not ready while output register is empty");

	// A stalled output word freezes the pipeline.
	a_hold_on_stall: assert property (@(posedge clk) (out_valid && !out_ready) |-> !in_ready)
		else $error("input accepted while output word is stalled");

	// Reset empties the pipeline.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// A stalled field word stays put.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(field_x) && $stable(field_y)))
		else $error("stalled field word changed");

	// No point word is accepted while a field word is stalled.
	a_in_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !(out_valid && !out_ready))
		else $error("word accepted during output stall");

endmodule

bind toroidal_field_evaluator fte_checker u_fte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pt_in.valid),
	.in_ready  (pt_in.ready),
	.out_valid (fld_out.valid),
	.out_ready (fld_out.ready),
	.field_x   (fld_out.field_x),
	.field_y   (fld_out.field_y)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for the toroidal field evaluator: directed and random points against a predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fte_pkg::*;

	// An index outside the register map; the block must ignore it.
	localparam logic [IW-1:0] REG_SPARE = 3'd7;
	localparam int PIPE_DRAIN = 80;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} point_t;

	typedef struct {
		logic signed [FW-1:0] fx;
		logic signed [FW-1:0] fy;
	} field_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [IW-1:0] wr_index;
	logic [CW-1:0] wr_data;

	fte_in_if pt_if();
	fte_out_if fld_if();

	toroidal_field_evaluator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pt_in(pt_if),
		.fld_out(fld_if),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// Magnet geometry as the predictor sees it.
	longint m_yoff, m_zoff, m_zlen, m_hw, m_ahh, m_ohh, m_field;

	point_t points_to_send[$];
	field_t fields_expected[$];
	int errors = 0;
	int accepted = 0;
	bit quiet = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Field of the magnet at one point, with rounding and saturation.
	function automatic field_t field_at(point_t p);
		longint x, y, z, ax, ay, az, fm, bx, by, qx, qy;
		logic [63:0] dx, ayu, fmu, r, t;
		logic [127:0] s, ih, oh;
		field_t f;
		x = longint'(p.x);
		y = longint'(p.y) - m_yoff;
		z = longint'(p.z) - m_zoff;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		fm = (m_field < 0) ? -m_field : m_field;
		bx = 0;
		by = 0;
		if (2 * az <= m_zlen) begin
			if (ax < m_hw) begin
				if (ay > m_ahh && ay < m_ohh)
					bx = m_field;
			end else if (ax - m_hw < m_ohh && ay < m_ohh) begin
				dx = ax - m_hw;
				ayu = ay;
				fmu = fm;
				s = {64'd0, dx} * {64'd0, dx} + {64'd0, ayu} * {64'd0, ayu};
				ih = 128'(m_ahh) * 128'(m_ahh);
				oh = 128'(m_ohh) * 128'(m_ohh);
				if (s > ih && s < oh) begin
					r = 0;
					for (int i = 47; i >= 0; i--) begin
						t = r | (64'd1 << i);
						if ({64'd0, t} * {64'd0, t} <= s)
							r = t;
					end
					if (s > {64'd0, r} * {64'd0, r} + {64'd0, r})
						r = r + 1;
					qx = longint'(({64'd0, fmu} * {64'd0, ayu} + {64'd0, r >> 1}) / {64'd0, r});
					qy = longint'(({64'd0, fmu} * {64'd0, dx} + {64'd0, r >> 1}) / {64'd0, r});
					bx = (m_field < 0) ? -qx : qx;
					by = (m_field < 0) ? qy : -qy;
				end
			end
		end
		if (x < 0) by = -by;
		if (y < 0) bx = -bx;
		if (bx > 131071) bx = 131071;
		if (bx < -131072) bx = -131072;
		if (by > 131071) by = 131071;
		if (by < -131072) by = -131072;
		f.fx = FW'(bx);
		f.fy = FW'(by);
		return f;
	endfunction

	// Point driver with random idle bursts.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_if.valid <= 1'b0;
			pt_if.x_pos <= '0;
			pt_if.y_pos <= '0;
			pt_if.z_pos <= '0;
		end else begin
			point_t p;
			if (pt_if.valid && pt_if.ready) begin
				p.x = pt_if.x_pos;
				p.y = pt_if.y_pos;
				p.z = pt_if.z_pos;
				fields_expected.push_back(field_at(p));
				accepted++;
			end
			if (!pt_if.valid || pt_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					pt_if.valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 15);
					pt_if.valid <= 1'b0;
				end else if (points_to_send.size() > 0) begin
					p = points_to_send.pop_front();
					pt_if.x_pos <= p.x;
					pt_if.y_pos <= p.y;
					pt_if.z_pos <= p.z;
					pt_if.valid <= 1'b1;
				end else begin
					pt_if.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls plus one long hold-off that fills the pipeline.
	int recv_gap = 0;
	int hold_cnt = 0;
	bit held = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fld_if.ready <= 1'b0;
		end else begin
			if (hold_cnt > 0) begin
				hold_cnt--;
				fld_if.ready <= 1'b0;
			end else if (!held && accepted >= 300) begin
				held = 1;
				hold_cnt = 300;
				fld_if.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				fld_if.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(0, 15);
				fld_if.ready <= 1'b0;
			end else begin
				fld_if.ready <= 1'b1;
			end
		end
	end

	// Field word checker.
	always @(posedge clk) begin
		if (arst_n && fld_if.valid && fld_if.ready) begin
			field_t e;
			if (fields_expected.size() == 0) begin
				$display("%0t: unexpected field word fx=%0d fy=%0d", $time,
					fld_if.field_x, fld_if.field_y);
				errors++;
			end else begin
				e = fields_expected.pop_front();
				if (e.fx !== fld_if.field_x) begin
					$display("%0t: field_x expected %0d actual %0d", $time, e.fx,
						fld_if.field_x);
					errors++;
				end
				if (e.fy !== fld_if.field_y) begin
					$display("%0t: field_y expected %0d actual %0d", $time, e.fy,
						fld_if.field_y);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] d);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		case (idx)
			REG_Y_OFFSET: m_yoff = longint'($signed(d));
			REG_Z_OFFSET: m_zoff = longint'($signed(d));
			REG_Z_LENGTH: m_zlen = longint'(d[LW-1:0]);
			REG_AP_HALF_W: m_hw = longint'(d[LW-1:0]);
			REG_AP_HALF_H: m_ahh = longint'(d[LW-1:0]);
			REG_OUT_HALF_H: m_ohh = longint'(d[LW-1:0]);
			REG_FIELD: m_field = longint'($signed(d[FW-1:0]));
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_magnet(longint yo, longint zo, longint zl, longint hw, longint ahh,
			longint ohh, longint f);
		write_reg(REG_Y_OFFSET, CW'(yo));
		write_reg(REG_Z_OFFSET, CW'(zo));
		write_reg(REG_Z_LENGTH, CW'(zl));
		write_reg(REG_AP_HALF_W, CW'(hw));
		write_reg(REG_AP_HALF_H, CW'(ahh));
		write_reg(REG_OUT_HALF_H, CW'(ohh));
		write_reg(REG_FIELD, CW'(f));
		write_reg(REG_SPARE, $urandom());
	endtask

	function automatic void add_point(longint x, longint y, longint z);
		point_t p;
		p.x = CW'(x);
		p.y = CW'(y);
		p.z = CW'(z);
		points_to_send.push_back(p);
	endfunction

	function automatic longint capped(longint v);
		return (v > 64'sd2147483647) ? 64'sd2147483647 : v;
	endfunction

	// Mostly points around the magnet, some anywhere.
	function automatic void add_random_points(int n);
		longint xs, ys, zs, sx, sy, sz;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				add_point($signed($urandom()), $signed($urandom()), $signed($urandom()));
			end else begin
				xs = capped(m_hw + m_ohh + 20);
				ys = capped(m_ohh + 20);
				zs = capped(m_zlen / 2 + 20);
				sx = $urandom_range(0, 32'(xs));
				sy = $urandom_range(0, 32'(ys));
				sz = $urandom_range(0, 32'(zs));
				add_point($urandom_range(0, 1) ? sx : -sx,
					m_yoff + ($urandom_range(0, 1) ? sy : -sy),
					m_zoff + ($urandom_range(0, 1) ? sz : -sz));
			end
		end
	endfunction

	task automatic drain();
		wait (points_to_send.size() == 0 && !pt_if.valid && fields_expected.size() == 0);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		pt_if.valid = 1'b0;
		fld_if.ready = 1'b0;
		m_yoff = 0; m_zoff = 0; m_zlen = 0; m_hw = 0; m_ahh = 0; m_ohh = 0; m_field = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry: zero field everywhere.
		add_point(0, 0, 0);
		add_point(-2147483648, 2147483647, -1);
		drain();

		// Directed points on a plain magnet.
		set_magnet(100, -50, 2000, 160, 80, 400, 65536);
		add_point(0, 300, -50);              // inside aperture, upper band
		add_point(-10, -100, 900);            // inside aperture, lower band, z at end
		add_point(5, 180, 951);              // just past half length
		add_point(160, 300, -50);            // aperture edge, dx zero
		add_point(-160, -300, 0);             // edge, negative x and y
		add_point(300, 250, 0);              // off the aperture, inside radius
		add_point(-300, -50, 0);             // negative x, negative y
		add_point(700, 100, 0);              // outside radius
		add_point(0, 100, 0);                // aperture, y on axis
		add_point(2147483647, 2147483647, 2147483647);
		add_point(-2147483648, -2147483648, -2147483648);
		drain();

		// Most negative field saturates on negation; zero aperture width.
		set_magnet(-7, 3, 4000, 0, 0, 1000, -131072);
		add_point(0, 500, 0);
		add_point(0, -493, 0);
		add_point(-1, 993, 0);
		add_point(3, 100, 0);
		add_point(400, -7, 1);
		add_random_points(80);
		drain();

		// Register extremes.
		set_magnet(-2147483648, 2147483647, 2147483647, 2147483647, 0, 2147483647, 131071);
		add_random_points(100);
		drain();
		set_magnet(2147483647, -2147483648, 0, 0, 2147483647, 2147483647, -131071);
		add_random_points(40);
		drain();
		set_magnet(0, 0, 2147483647, 1, 0, 2147483647, -131072);
		add_random_points(100);
		drain();

		// Random geometries, small sizes mostly.
		for (int ph = 0; ph < 8; ph++) begin
			longint ahh;
			ahh = $urandom_range(0, 1500);
			if (ph == 7) quiet = 1;
			set_magnet($signed($urandom_range(0, 200000)) - 100000,
				$signed($urandom_range(0, 200000)) - 100000,
				$urandom_range(0, 8000), $urandom_range(0, 2000), ahh,
				ahh + $urandom_range(0, 3000),
				longint'($signed(18'($urandom()))));
			add_random_points(100);
			drain();
		end

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/fte_pkg.sv
rtl/core/fte_ifs.sv
rtl/core/fte_front.sv
rtl/core/fte_sqrt.sv
rtl/core/fte_div.sv
rtl/core/toroidal_field_evaluator.sv
rtl/core/fte_checker.sv
verif/testbench.sv
